// ----- hdl/ppc_pkg.sv -----
// Shared types, register indexes and constants of the pressure pump controller.
package ppc_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  localparam logic [CfgIndexWidth-1:0] REG_SENSOR_HIGH  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_SENSOR_LOW   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_START_PRESS  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_STOP_PRESS   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_MIN_RISE     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_RISE_TIMEOUT = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_TICKS_PER_S  = 3'd6;

  localparam logic [11:0]        SENSOR_HIGH_RST  = 12'd3827;
  localparam logic [11:0]        SENSOR_LOW_RST   = 12'd379;
  localparam logic signed [14:0] START_PRESS_RST  = 15'sd1000;
  localparam logic signed [14:0] STOP_PRESS_RST   = 15'sd2000;
  localparam logic [9:0]         MIN_RISE_RST     = 10'd50;
  localparam logic [31:0]        RISE_TIMEOUT_RST = 32'd72000000;
  localparam logic [31:0]        TICKS_PER_S_RST  = 32'd72000000;

  // Sensor counts to millibar: mbar = (adc * 1049 >> 8) - 1724.
  localparam logic [10:0]        MBAR_GAIN   = 11'd1049;
  localparam logic signed [15:0] MBAR_OFFSET = 16'sd1724;

  localparam int unsigned FLAG_OVER  = 0;
  localparam int unsigned FLAG_BREAK = 1;
  localparam int unsigned FLAG_SLOW  = 2;

  typedef struct packed {
    logic [11:0]        sensor_high;
    logic [11:0]        sensor_low;
    logic signed [14:0] start_press;
    logic signed [14:0] stop_press;
    logic [9:0]         min_rise;
    logic [31:0]        rise_timeout;
    logic [31:0]        ticks_per_s;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic mul;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- hdl/ppc_in_if.sv -----
// Sample channel: valid/ready handshake with sensor reading and timestamp.
interface ppc_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] adc_sample;
  logic [31:0] time_ticks;

  modport source (output valid, output adc_sample, output time_ticks, input ready);
  modport sink   (input valid, input adc_sample, input time_ticks, output ready);
endinterface

// ----- hdl/ppc_out_if.sv -----
// Result channel: valid/ready handshake with pump drive, faults and pressure.
interface ppc_out_if;
  logic               valid;
  logic               ready;
  logic               pump_drive;
  logic [2:0]         fault_flags;
  logic signed [14:0] pressure_mbar;

  modport source (output valid, output pump_drive, output fault_flags,
                  output pressure_mbar, input ready);
  modport sink   (input valid, input pump_drive, input fault_flags,
                  input pressure_mbar, output ready);
endinterface

// ----- hdl/pressure_pump_controller.sv -----
// A result beat is registered once the sequencer has stepped its sample through
// the convert, multiply and commit states; no new sample is taken before that
// commit, and commit waits while an older result beat is unread.
// Reset: asynchronous, active low; pump run state off, no faults, stored pressure and times
// zero, configuration registers back to their defaults.
module pressure_pump_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ppc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [ppc_pkg::CfgDataWidth-1:0]   cfg_data_i,
  ppc_in_if.sink                             sample_i,
  ppc_out_if.source                          result_o
);
  import ppc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ppc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ppc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .adc_sample_i    (sample_i.adc_sample),
    .time_ticks_i    (sample_i.time_ticks),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .pump_drive_o    (result_o.pump_drive),
    .fault_flags_o   (result_o.fault_flags),
    .pressure_mbar_o (result_o.pressure_mbar)
  );

endmodule

// ----- hdl/ppc_cfg.sv -----
// Configuration register bank with reset defaults.
module ppc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ppc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [ppc_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output ppc_pkg::cfg_t                      cfg_o
);
  import ppc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SENSOR_HIGH:  cfg_d.sensor_high  = cfg_data_i[11:0];
        REG_SENSOR_LOW:   cfg_d.sensor_low   = cfg_data_i[11:0];
        REG_START_PRESS:  cfg_d.start_press  = signed'(cfg_data_i[14:0]);
        REG_STOP_PRESS:   cfg_d.stop_press   = signed'(cfg_data_i[14:0]);
        REG_MIN_RISE:     cfg_d.min_rise     = cfg_data_i[9:0];
        REG_RISE_TIMEOUT: cfg_d.rise_timeout = cfg_data_i;
        REG_TICKS_PER_S:  cfg_d.ticks_per_s  = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_high  <= SENSOR_HIGH_RST;
      cfg_q.sensor_low   <= SENSOR_LOW_RST;
      cfg_q.start_press  <= START_PRESS_RST;
      cfg_q.stop_press   <= STOP_PRESS_RST;
      cfg_q.min_rise     <= MIN_RISE_RST;
      cfg_q.rise_timeout <= RISE_TIMEOUT_RST;
      cfg_q.ticks_per_s  <= TICKS_PER_S_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/ppc_ctrl.sv -----
// Sequencer that steps one sample through convert, multiply and commit.
module ppc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ppc_pkg::dp_stat_t  stat_i,
  output ppc_pkg::dp_cmd_t   cmd_o
);
  import ppc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // Hold here while the previous result beat is still waiting.
        if (!stat_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ----- hdl/ppc_dp.sv -----
// Datapath: pressure conversion, rise-rate products, fault and pump state.
module ppc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppc_pkg::cfg_t       cfg_i,
  input  ppc_pkg::dp_cmd_t    cmd_i,
  output ppc_pkg::dp_stat_t   stat_o,
  input  logic [11:0]         adc_sample_i,
  input  logic [31:0]         time_ticks_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                pump_drive_o,
  output logic [2:0]          fault_flags_o,
  output logic signed [14:0]  pressure_mbar_o
);
  import ppc_pkg::*;

  // Sample capture and intermediate results.
  logic [11:0]        adc_q;
  logic [31:0]        time_q;
  logic               over_q, brk_q;
  logic signed [15:0] press_q;
  logic signed [16:0] diff_q;
  logic [31:0]        dt_q, elapsed_q;
  logic signed [49:0] lhs_q;
  logic [41:0]        rhs_q;
  logic               late_q;

  // Controller state.
  logic signed [15:0] last_press_q, last_press_d;
  logic [31:0]        last_time_q, last_time_d;
  logic [31:0]        start_time_q, start_time_d;
  logic               running_q, running_d;
  logic [2:0]         faults_q, faults_d;

  // Result register.
  logic               out_valid_q;
  logic               out_pump_q;
  logic [2:0]         out_flags_q;
  logic signed [14:0] out_press_q;

  logic [22:0]        prod;
  logic signed [15:0] press_c;
  logic               slow;

  assign prod    = 23'(adc_q) * 23'(MBAR_GAIN);
  assign press_c = signed'({1'b0, prod[22:8]}) - MBAR_OFFSET;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adc_q  <= adc_sample_i;
      time_q <= time_ticks_i;
    end
    if (cmd_i.conv) begin
      over_q    <= adc_q > cfg_i.sensor_high;
      brk_q     <= adc_q < cfg_i.sensor_low;
      press_q   <= press_c;
      diff_q    <= 17'(press_c) - 17'(last_press_q);
      dt_q      <= time_q - last_time_q;
      elapsed_q <= time_q - start_time_q;
    end
    if (cmd_i.mul) begin
      lhs_q  <= 50'(diff_q) * signed'(50'(cfg_i.ticks_per_s));
      rhs_q  <= 42'(cfg_i.min_rise) * 42'(dt_q);
      late_q <= elapsed_q > cfg_i.rise_timeout;
    end
  end

  assign slow = running_q && (lhs_q < signed'(50'(rhs_q))) && late_q;

  always_comb begin
    last_press_d = last_press_q;
    last_time_d  = last_time_q;
    start_time_d = start_time_q;
    running_d    = running_q;
    faults_d     = faults_q;
    if (cmd_i.commit) begin
      priority if (over_q) begin
        faults_d[FLAG_OVER] = 1'b1;
      end else if (brk_q) begin
        faults_d[FLAG_BREAK] = 1'b1;
      end else begin
        faults_d[FLAG_OVER]  = 1'b0;
        faults_d[FLAG_BREAK] = 1'b0;
        if (slow) begin
          faults_d[FLAG_SLOW] = 1'b1;
        end else begin
          last_press_d = press_q;
          last_time_d  = time_q;
        end
      end
      if (faults_d != '0) begin
        running_d = 1'b0;
      end else begin
        if ((last_press_d < 16'(cfg_i.start_press)) && !running_d) begin
          running_d    = 1'b1;
          start_time_d = time_q;
        end
        if ((last_press_d > 16'(cfg_i.stop_press)) && running_d) begin
          running_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_press_q <= '0;
      last_time_q  <= '0;
      start_time_q <= '0;
      running_q    <= 1'b0;
      faults_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      last_press_q <= last_press_d;
      last_time_q  <= last_time_d;
      start_time_q <= start_time_d;
      running_q    <= running_d;
      faults_q     <= faults_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_pump_q  <= running_d;
      out_flags_q <= faults_d;
      out_press_q <= last_press_d[14:0];
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign pump_drive_o    = out_pump_q;
  assign fault_flags_o   = out_flags_q;
  assign pressure_mbar_o = out_press_q;

endmodule

// ----- test/tb_pressure_pump_controller.sv -----
// Self-checking testbench for the pressure pump controller with its own predictor.
module tb_pressure_pump_controller;
  import ppc_pkg::*;

  typedef struct {
    logic [11:0] adc;
    logic [31:0] ticks;
    int unsigned gap;
  } sample_t;

  typedef struct packed {
    logic               pump;
    logic [2:0]         faults;
    logic signed [14:0] press;
  } reading_t;

  localparam cfg_t CFG_DEFAULT = '{SENSOR_HIGH_RST, SENSOR_LOW_RST, START_PRESS_RST,
                                   STOP_PRESS_RST, MIN_RISE_RST, RISE_TIMEOUT_RST,
                                   TICKS_PER_S_RST};

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b1;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i = '0;

  ppc_in_if  smp ();
  ppc_out_if res ();

  pressure_pump_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (smp),
    .result_o    (res)
  );

  always #6 clk_i = ~clk_i;

  // Controller state as the predictor sees it, plus its copy of the registers.
  cfg_t        cfg_shadow = CFG_DEFAULT;
  int          ctl_press = 0;
  logic [31:0] ctl_last_t = '0;
  logic [31:0] ctl_start_t = '0;
  logic        ctl_run = 1'b0;
  logic [2:0]  ctl_faults = '0;

  sample_t     samples_pending[$];
  reading_t    readings_due[$];
  logic [31:0] gen_t = '0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_rx = 1'b0;
  int unsigned tx_wait, rx_wait;
  int unsigned n_taken = 0, n_checked = 0, n_errors = 0, n_on = 0, n_faulted = 0;

  function automatic reading_t control_step(logic [11:0] adc, logic [31:0] t);
    int       p;
    longint   rise;
    longint   need;
    bit       slow;
    reading_t r;
    if (adc > cfg_shadow.sensor_high) begin
      ctl_faults[FLAG_OVER] = 1'b1;
    end else if (adc < cfg_shadow.sensor_low) begin
      ctl_faults[FLAG_BREAK] = 1'b1;
    end else begin
      ctl_faults[FLAG_OVER] = 1'b0;
      ctl_faults[FLAG_BREAK] = 1'b0;
      p = int'(({20'd0, adc} * 32'd1049) >> 8) - 1724;
      slow = 1'b0;
      if (ctl_run) begin
        // Rate test by cross-multiplication: rise * ticks/s < min rate * elapsed ticks.
        rise = longint'(p - ctl_press) * longint'({32'd0, cfg_shadow.ticks_per_s});
        need = longint'({54'd0, cfg_shadow.min_rise}) * longint'({32'd0, t - ctl_last_t});
        slow = (rise < need) && ((t - ctl_start_t) > cfg_shadow.rise_timeout);
      end
      if (slow) begin
        ctl_faults[FLAG_SLOW] = 1'b1;
      end else begin
        ctl_press = p;
        ctl_last_t = t;
      end
    end
    if (ctl_faults != 3'd0) begin
      ctl_run = 1'b0;
    end else begin
      if (ctl_press < int'($signed(cfg_shadow.start_press)) && !ctl_run) begin
        ctl_run = 1'b1;
        ctl_start_t = t;
      end
      if (ctl_press > int'($signed(cfg_shadow.stop_press)) && ctl_run) ctl_run = 1'b0;
    end
    r.pump = ctl_run;
    r.faults = ctl_faults;
    r.press = ctl_press[14:0];
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic note_error(string msg);
    n_errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic queue_sample(logic [11:0] adc, logic [31:0] dt);
    int unsigned gap;
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    gen_t += dt;
    samples_pending.push_back('{adc, gen_t, gap});
  endtask

  // Returns once every queued sample is taken and every reading has come back.
  task automatic settle();
    do @(negedge clk_i);
    while (samples_pending.size() != 0 || smp.valid || readings_due.size() != 0);
  endtask

  task automatic set_cfg(cfg_t c);
    logic [CfgIndexWidth-1:0] regs [7] = '{REG_SENSOR_HIGH, REG_SENSOR_LOW, REG_START_PRESS,
                                           REG_STOP_PRESS, REG_MIN_RISE, REG_RISE_TIMEOUT,
                                           REG_TICKS_PER_S};
    logic [31:0] vals [7];
    vals[0] = {20'd0, c.sensor_high};
    vals[1] = {20'd0, c.sensor_low};
    vals[2] = {17'd0, c.start_press};
    vals[3] = {17'd0, c.stop_press};
    vals[4] = {22'd0, c.min_rise};
    vals[5] = c.rise_timeout;
    vals[6] = c.ticks_per_s;
    settle();
    for (int k = 0; k < 7; k++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= regs[k];
      cfg_data_i <= vals[k];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_shadow = c;
  endtask

  // Sawtooth pressure walk across the hysteresis band, with out-of-window noise.
  task automatic run_phase(int n);
    int lo_p, hi_p, walk_lo, walk_hi, walk_adc, step;
    int unsigned r, dt;
    bit walk_up;
    lo_p = int'($signed(cfg_shadow.start_press));
    hi_p = int'($signed(cfg_shadow.stop_press));
    if (lo_p > hi_p) begin
      lo_p = int'($signed(cfg_shadow.stop_press));
      hi_p = int'($signed(cfg_shadow.start_press));
    end
    walk_lo = (lo_p + 1724) * 256 / 1049 - 40;
    walk_hi = (hi_p + 1724) * 256 / 1049 + 40;
    if (walk_lo < 0) walk_lo = 0;
    if (walk_hi > 4095) walk_hi = 4095;
    if (walk_hi <= walk_lo + 50) begin
      walk_lo = 0;
      walk_hi = 4095;
    end
    walk_adc = walk_lo;
    walk_up = 1'b1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      dt = $urandom_range(0, 99);
      if (dt < 5) dt = 0;
      else if (dt < 75) dt = $urandom_range(1, 200);
      else if (dt < 95) dt = $urandom_range(1, 2000000);
      else dt = $urandom;
      if (r < 4) begin
        queue_sample(12'($urandom), dt);
      end else if (r < 8) begin
        queue_sample((r & 1) ? 12'(4095 - $urandom_range(0, 200)) :
                     12'($urandom_range(0, 300)), dt);
      end else begin
        if ($urandom_range(0, 19) == 0) walk_up = !walk_up;
        step = $urandom_range(1, 24);
        if (walk_up) begin
          walk_adc += step;
          if (walk_adc >= walk_hi) begin
            walk_adc = walk_hi;
            walk_up = 1'b0;
          end
        end else begin
          walk_adc -= step;
          if (walk_adc <= walk_lo) begin
            walk_adc = walk_lo;
            walk_up = 1'b1;
          end
        end
        queue_sample(12'(walk_adc), dt);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    sample_t nxt;
    bit      free;
    if (!rst_ni) begin
      smp.valid <= 1'b0;
      smp.adc_sample <= '0;
      smp.time_ticks <= '0;
      tx_wait = 0;
    end else begin
      free = !smp.valid;
      if (smp.valid && smp.ready) begin
        readings_due.push_back(control_step(smp.adc_sample, smp.time_ticks));
        n_taken++;
        free = 1'b1;
      end
      if (free) begin
        if (tx_wait != 0) begin
          tx_wait--;
          smp.valid <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          nxt = samples_pending.pop_front();
          smp.valid <= 1'b1;
          smp.adc_sample <= nxt.adc;
          smp.time_ticks <= nxt.ticks;
          tx_wait = nxt.gap;
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reading_t want;
    if (!rst_ni) begin
      res.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (readings_due.size() == 0) begin
          note_error("result beat with no sample outstanding");
        end else begin
          want = readings_due.pop_front();
          n_checked++;
          if (want.pump) n_on++;
          if (want.faults != 3'd0) n_faulted++;
          if (res.pump_drive !== want.pump)
            note_error($sformatf("pump_drive %b, expected %b", res.pump_drive, want.pump));
          if (res.fault_flags !== want.faults)
            note_error($sformatf("fault_flags %b, expected %b", res.fault_flags, want.faults));
          if (res.pressure_mbar !== want.press)
            note_error($sformatf("pressure_mbar %0d, expected %0d",
                                 res.pressure_mbar, want.press));
        end
      end
      if (rx_wait != 0) begin
        rx_wait--;
        res.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
        rx_wait = idle_len() - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !hold_rx;
      end
    end
  end

  // Long receiver hold-off while samples keep coming, so the block backs up.
  initial begin : backlog
    while (n_taken < 260) @(negedge clk_i);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("Timed out with %0d readings outstanding", readings_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [11:0] a_adc [16] = '{12'd0, 12'd4095, 12'd379, 12'd378, 12'd3828, 12'd3827,
                                12'd1000, 12'd600, 12'd600, 12'd700, 12'd900, 12'd950,
                                12'd850, 12'd500, 12'hAAA, 12'h555};
    int unsigned a_dt [16] = '{100, 100, 100, 100, 100, 100, 1000, 1000, 0, 1000, 1000,
                               1000, 1000, 1000, 1000, 1000};
    cfg_t c;
    int   lo_p, hi_p;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Window edges, flag pairs, hysteresis and a zero time step, all at reset values.
    for (int k = 0; k < 16; k++) queue_sample(a_adc[k], a_dt[k]);

    // Crossed sensor limits: over-voltage wins. Then crossed pressure limits.
    c = cfg_shadow;
    c.sensor_high = 12'd100;
    c.sensor_low = 12'd200;
    c.start_press = 15'sd3000;
    c.stop_press = 15'sd500;
    c.min_rise = 10'd1000;
    c.rise_timeout = '1;
    c.ticks_per_s = 32'd1;
    set_cfg(c);
    queue_sample(12'd150, 10);
    queue_sample(12'd50, 10);
    c.sensor_high = 12'd4095;
    c.sensor_low = 12'd0;
    set_cfg(c);
    queue_sample(12'd0, 10);
    queue_sample(12'd2000, 10);
    queue_sample(12'd665, 10);

    // The slow-rise flag latches for good, so these phases keep the timeout out of reach.
    for (int ph = 0; ph < 6; ph++) begin
      c = cfg_shadow;
      unique case (ph)
        0: begin
          c = CFG_DEFAULT;
          c.rise_timeout = '1;
        end
        2: begin
          c.sensor_high = 12'd4095;
          c.sensor_low = 12'd0;
          c.start_press = -15'sd1724;
          c.stop_press = 15'sd15058;
          c.min_rise = 10'd0;
          c.ticks_per_s = '1;
        end
        3: begin
          c.sensor_high = 12'd4095;
          c.sensor_low = 12'd0;
          c.start_press = 15'sd15058;
          c.stop_press = -15'sd1724;
          c.min_rise = 10'd1000;
          c.ticks_per_s = 32'd1;
        end
        default: begin
          c.sensor_high = 12'($urandom_range(2800, 4095));
          c.sensor_low = 12'($urandom_range(0, 1200));
          lo_p = int'($urandom_range(0, 9000)) - 1724;
          hi_p = lo_p + int'($urandom_range(100, 4000));
          c.start_press = 15'(lo_p);
          c.stop_press = 15'(hi_p);
          if ($urandom_range(0, 9) == 0) begin
            c.start_press = 15'(hi_p);
            c.stop_press = 15'(lo_p);
          end
          c.min_rise = 10'($urandom_range(0, 1000));
          c.rise_timeout = '1;
          c.ticks_per_s = $urandom;
        end
      endcase
      set_cfg(c);
      tx_calm = (ph == 0 || ph == 4);
      rx_calm = (ph == 0);
      run_phase((ph == 2 || ph == 3) ? 40 : 70);
    end

    // Zero ticks per second and zero minimum rate: the rise is never slow.
    c = CFG_DEFAULT;
    c.min_rise = 10'd0;
    c.rise_timeout = '0;
    c.ticks_per_s = '0;
    set_cfg(c);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    run_phase(40);

    // Realistic supervision: a falling pressure while pumping latches the slow-rise flag.
    c.min_rise = 10'd50;
    c.rise_timeout = 32'd5000;
    c.ticks_per_s = 32'd1000;
    set_cfg(c);
    run_phase(60);

    settle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d readings from %0d samples over ten register settings;",
             n_checked, n_taken);
    $display("pump on in %0d readings, a fault flag up in %0d, slow-rise latch %s.",
             n_on, n_faulted, ctl_faults[FLAG_SLOW] ? "reached" : "not reached");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
